// ----- rtl/core/i2c_mbe_pkg.sv -----
// i2c_mbe_pkg: types, codes and the per-action step function of the i2c master bit engine
// used by the channel interfaces, the sequencer core and the top level
// no dependencies

package i2c_mbe_pkg;

  // operation codes of a command beat
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_RESTART   = 3'd3,
    OP_WRITE     = 3'd4,
    OP_READ      = 3'd5,
    OP_BUS_RESET = 3'd6
  } op_e;

  // sequencer phases, one action each
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST_A = 5'd1,
    PH_ST_B = 5'd2,
    PH_SP_A = 5'd3,
    PH_SP_B = 5'd4,
    PH_SP_C = 5'd5,
    PH_RS_A = 5'd6,
    PH_RS_B = 5'd7,
    PH_RS_C = 5'd8,
    PH_RS_D = 5'd9,
    PH_RS_E = 5'd10,
    PH_RS_F = 5'd11,
    PH_WR_D = 5'd12,
    PH_WR_H = 5'd13,
    PH_WR_L = 5'd14,
    PH_AK_H = 5'd15,
    PH_AK_S = 5'd16,
    PH_AK_E = 5'd17,
    PH_RD_R = 5'd18,
    PH_RD_H = 5'd19,
    PH_RD_S = 5'd20,
    PH_RD_Z = 5'd21,
    PH_NA_D = 5'd22,
    PH_NA_H = 5'd23,
    PH_NA_L = 5'd24,
    PH_BR_L = 5'd25,
    PH_BR_H = 5'd26,
    PH_BR_P = 5'd27,
    PH_FIN  = 5'd28
  } phase_e;

  // wait lengths in delay units
  typedef enum logic [1:0] {
    WAIT_0  = 2'd0,
    WAIT_1  = 2'd1,
    WAIT_2  = 2'd2,
    WAIT_10 = 2'd3
  } wait_e;

  localparam int unsigned TpuW        = 16;
  localparam int unsigned DelayW      = 20;
  localparam logic [TpuW-1:0] TPU_RESET = 16'd100;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [3:0] BUS_RST_PULSES = 4'd9;

  // command beat
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_byte;
    logic       ack_seen;
  } res_t;

  // sequencer state
  typedef struct packed {
    phase_e              phase;
    logic [3:0]          bit_cnt;
    logic [7:0]          shift;
    logic [DelayW-1:0]   delay;
    logic                scl;
    logic                sda;
    logic                ack_flag;
    logic                ack_req;
    logic [7:0]          rx;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:    PH_IDLE,
    bit_cnt:  4'd0,
    shift:    8'd0,
    delay:    '0,
    scl:      1'b1,
    sda:      1'b1,
    ack_flag: 1'b0,
    ack_req:  1'b0,
    rx:       8'd0
  };

  typedef struct packed {
    state_t st;
    logic   done;
  } act_t;

  // wait length in ticks, ten units as 8t + 2t
  function automatic logic [DelayW-1:0] delay_load(wait_e w, logic [TpuW-1:0] tpu);
    logic [DelayW-1:0] r;
    case (w)
      WAIT_0:  r = '0;
      WAIT_1:  r = {4'd0, tpu};
      WAIT_2:  r = {3'd0, tpu, 1'b0};
      WAIT_10: r = {1'b0, tpu, 3'b000} + {3'd0, tpu, 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // one action of the sequencer: set lines, sample sda, load the next wait
  function automatic act_t act_step(state_t s, logic sda_in, logic [TpuW-1:0] tpu);
    act_t       r;
    wait_e      w;
    logic [3:0] cnt_inc;
    r       = '{st: s, done: 1'b0};
    w       = WAIT_0;
    cnt_inc = s.bit_cnt + 4'd1;
    case (s.phase)
      PH_ST_A: begin r.st.sda = 1'b0; w = WAIT_1; r.st.phase = PH_ST_B; end
      PH_ST_B: begin r.st.scl = 1'b0; w = WAIT_0; r.st.phase = PH_FIN; end
      PH_SP_A: begin
        r.st.scl = 1'b0; r.st.sda = 1'b0; w = WAIT_1; r.st.phase = PH_SP_B;
      end
      PH_SP_B: begin r.st.scl = 1'b1; w = WAIT_1; r.st.phase = PH_SP_C; end
      PH_SP_C: begin r.st.sda = 1'b1; w = WAIT_0; r.st.phase = PH_FIN; end
      PH_RS_A: begin w = WAIT_1; r.st.phase = PH_RS_B; end
      PH_RS_B: begin r.st.scl = 1'b0; w = WAIT_1; r.st.phase = PH_RS_C; end
      PH_RS_C: begin r.st.sda = 1'b1; w = WAIT_1; r.st.phase = PH_RS_D; end
      PH_RS_D: begin r.st.scl = 1'b1; w = WAIT_2; r.st.phase = PH_RS_E; end
      PH_RS_E: begin r.st.sda = 1'b0; w = WAIT_1; r.st.phase = PH_RS_F; end
      PH_RS_F: begin r.st.scl = 1'b0; w = WAIT_0; r.st.phase = PH_FIN; end
      PH_WR_D: begin r.st.sda = s.shift[7]; w = WAIT_1; r.st.phase = PH_WR_H; end
      PH_WR_H: begin r.st.scl = 1'b1; w = WAIT_1; r.st.phase = PH_WR_L; end
      PH_WR_L: begin
        r.st.scl     = 1'b0;
        r.st.shift   = {s.shift[6:0], 1'b0};
        r.st.bit_cnt = cnt_inc;
        w            = WAIT_0;
        r.st.phase   = (cnt_inc < BITS_PER_BYTE) ? PH_WR_D : PH_AK_H;
      end
      PH_AK_H: begin
        r.st.sda = 1'b1; r.st.scl = 1'b1; w = WAIT_2; r.st.phase = PH_AK_S;
      end
      PH_AK_S: begin
        r.st.ack_flag = ~sda_in; r.st.scl = 1'b0; w = WAIT_1; r.st.phase = PH_AK_E;
      end
      PH_AK_E: begin r.st.sda = 1'b0; w = WAIT_0; r.st.phase = PH_FIN; end
      PH_RD_R: begin
        r.st.sda = 1'b1; r.st.bit_cnt = 4'd0; r.st.shift = 8'd0;
        w = WAIT_1; r.st.phase = PH_RD_H;
      end
      PH_RD_H: begin r.st.scl = 1'b1; w = WAIT_1; r.st.phase = PH_RD_S; end
      PH_RD_S: begin
        r.st.shift   = {s.shift[6:0], sda_in};
        r.st.scl     = 1'b0;
        r.st.bit_cnt = cnt_inc;
        w            = WAIT_1;
        r.st.phase   = (cnt_inc < BITS_PER_BYTE) ? PH_RD_H : PH_RD_Z;
      end
      PH_RD_Z: begin
        r.st.sda = 1'b0; r.st.rx = s.shift; w = WAIT_1; r.st.phase = PH_NA_D;
      end
      PH_NA_D: begin r.st.sda = ~s.ack_req; w = WAIT_2; r.st.phase = PH_NA_H; end
      PH_NA_H: begin r.st.scl = 1'b1; w = WAIT_2; r.st.phase = PH_NA_L; end
      PH_NA_L: begin r.st.scl = 1'b0; w = WAIT_1; r.st.phase = PH_FIN; end
      PH_BR_L: begin
        r.st.scl = 1'b0; r.st.bit_cnt = 4'd0; w = WAIT_10; r.st.phase = PH_BR_H;
      end
      PH_BR_H: begin r.st.scl = 1'b1; w = WAIT_1; r.st.phase = PH_BR_P; end
      PH_BR_P: begin
        r.st.scl     = 1'b0;
        r.st.bit_cnt = cnt_inc;
        w            = WAIT_1;
        r.st.phase   = (cnt_inc < BUS_RST_PULSES) ? PH_BR_H : PH_FIN;
      end
      // finish: back to idle
      default: begin
        r.st.phase = PH_IDLE;
        r.done     = 1'b1;
      end
    endcase
    r.st.delay = delay_load(w, tpu);
    return r;
  endfunction

endpackage

// ----- rtl/core/i2c_mbe_cmd_if.sv -----
// i2c_mbe_cmd_if: valid/ready channel carrying command and tick beats
// depends on i2c_mbe_pkg

interface i2c_mbe_cmd_if;
  logic               valid;
  logic               ready;
  i2c_mbe_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/i2c_mbe_res_if.sv -----
// i2c_mbe_res_if: valid/ready channel carrying result beats
// depends on i2c_mbe_pkg

interface i2c_mbe_res_if;
  logic               valid;
  logic               ready;
  i2c_mbe_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/i2c_mbe_core.sv -----
// i2c_mbe_core: sequencer state, delay counter and timing register of the bit engine
// depends on i2c_mbe_pkg (state types and the action step function)

module i2c_mbe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  i2c_mbe_pkg::cmd_t             cmd_i,
  input  logic                          cfg_we_i,
  input  logic [i2c_mbe_pkg::TpuW-1:0]  cfg_data_i,
  output i2c_mbe_pkg::res_t             res_o
);

  i2c_mbe_pkg::state_t               state_q, state_d;
  i2c_mbe_pkg::state_t               s_entry;
  i2c_mbe_pkg::act_t                 act_a, act_b;
  i2c_mbe_pkg::state_t               s_final;
  logic                              done;
  logic [i2c_mbe_pkg::TpuW-1:0]      tpu_q, tpu_eff;

  // timing register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= i2c_mbe_pkg::TPU_RESET;
    end else if (cfg_we_i) begin
      tpu_q <= cfg_data_i;
    end
  end

  // zero counts as one tick per unit
  assign tpu_eff = (tpu_q == '0) ? {{(i2c_mbe_pkg::TpuW-1){1'b0}}, 1'b1} : tpu_q;

  // command launch or delay countdown
  always_comb begin
    s_entry = state_q;
    if (state_q.phase == i2c_mbe_pkg::PH_IDLE) begin
      case (i2c_mbe_pkg::op_e'(cmd_i.operation))
        i2c_mbe_pkg::OP_START: begin
          s_entry.phase = i2c_mbe_pkg::PH_ST_A;
        end
        i2c_mbe_pkg::OP_STOP: begin
          s_entry.phase = i2c_mbe_pkg::PH_SP_A;
        end
        i2c_mbe_pkg::OP_RESTART: begin
          s_entry.phase = i2c_mbe_pkg::PH_RS_A;
        end
        i2c_mbe_pkg::OP_WRITE: begin
          s_entry.phase = i2c_mbe_pkg::PH_WR_D;
          s_entry.shift = cmd_i.data_byte;
        end
        i2c_mbe_pkg::OP_READ: begin
          s_entry.phase   = i2c_mbe_pkg::PH_RD_R;
          s_entry.ack_req = cmd_i.send_ack;
        end
        i2c_mbe_pkg::OP_BUS_RESET: begin
          s_entry.phase = i2c_mbe_pkg::PH_BR_L;
        end
        default: begin
          s_entry.phase = i2c_mbe_pkg::PH_IDLE;
        end
      endcase
      if (s_entry.phase != i2c_mbe_pkg::PH_IDLE) begin
        s_entry.delay   = '0;
        s_entry.bit_cnt = 4'd0;
      end
    end else if (state_q.delay != '0) begin
      s_entry.delay = state_q.delay - {{(i2c_mbe_pkg::DelayW-1){1'b0}}, 1'b1};
    end
  end

  // up to two chained actions: only a zero wait lets a second one follow
  always_comb begin
    act_a = '{st: s_entry, done: 1'b0};
    if (s_entry.phase != i2c_mbe_pkg::PH_IDLE && s_entry.delay == '0) begin
      act_a = i2c_mbe_pkg::act_step(s_entry, cmd_i.sda_in, tpu_eff);
    end
    act_b = '{st: act_a.st, done: 1'b0};
    if (!act_a.done && act_a.st.phase != i2c_mbe_pkg::PH_IDLE && act_a.st.delay == '0) begin
      act_b = i2c_mbe_pkg::act_step(act_a.st, cmd_i.sda_in, tpu_eff);
    end
    s_final = act_b.st;
    done    = act_a.done | act_b.done;
  end

  // state advances once per accepted beat
  assign state_d = fire_i ? s_final : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2c_mbe_pkg::STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // result of this beat
  assign res_o = '{
    scl_level:     s_final.scl,
    sda_release:   s_final.sda,
    busy_res:      (s_final.phase != i2c_mbe_pkg::PH_IDLE),
    done_res:      done,
    received_byte: s_final.rx,
    ack_seen:      s_final.ack_flag
  };

endmodule

// ----- rtl/core/i2c_mbe_outreg.sv -----
// i2c_mbe_outreg: result register between the sequencer and the result channel
// depends on i2c_mbe_pkg and i2c_mbe_res_if

module i2c_mbe_outreg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  i2c_mbe_pkg::res_t     res_i,
  output logic                  space_o,
  i2c_mbe_res_if.source         res_o
);

  logic               valid_q, valid_d;
  i2c_mbe_pkg::res_t  data_q, data_d;

  // room for a new beat when empty or being drained
  assign space_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (fire_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

endmodule

// ----- rtl/core/i2c_master_bit_engine.sv -----
// i2c_master_bit_engine: top level of the bit-level i2c master
// depends on i2c_mbe_pkg, i2c_mbe_cmd_if, i2c_mbe_res_if, i2c_mbe_core, i2c_mbe_outreg

// Every beat on cmd_i (a command or a plain tick) gives exactly one result beat on
// res_o in the following cycle, and the engine takes one beat per clock cycle while
// res_o is not stalled: the whole sequencer step (command launch, delay countdown
// and up to two chained bus actions) sits between the state registers and the
// result register. cmd_i.ready is high whenever the result register is empty or
// its beat is taken in the same cycle. Commands arriving while a sequence runs are
// treated as ticks. Bus timing counts in delay units of ticks_per_delay_unit beats,
// written through cfg_we_i and cfg_data_i (reset 100, zero acts as one).

module i2c_master_bit_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2c_mbe_pkg::TpuW-1:0]  cfg_data_i,
  i2c_mbe_cmd_if.sink                   cmd_i,
  i2c_mbe_res_if.source                 res_o
);

  logic               fire;
  logic               space;
  i2c_mbe_pkg::res_t  res_next;

  assign cmd_i.ready = space;
  assign fire        = cmd_i.valid && space;

  // sequencer
  i2c_mbe_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (cmd_i.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_next)
  );

  // result register
  i2c_mbe_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .res_i   (res_next),
    .space_o (space),
    .res_o   (res_o)
  );

`ifndef NO_ASSERTIONS
  // a completed sequence is never reported busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.data.done_res && res_o.data.busy_res))
    else $error("done and busy reported together");

  // every accepted beat shows up as a result beat next cycle
  a_beat_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> res_o.valid)
    else $error("accepted beat gave no result");

  // a stalled result blocks new beats
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !cmd_i.ready)
    else $error("beat accepted over a stalled result");
`endif

endmodule
